>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sensor fault debounce checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is low
`define SFDM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, masked while reset is low
`define SFDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that also holds through reset
`define SFDM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/sfdm_pkg.sv
// ----------------------------------------------------------------------------
// sfdm_pkg
// Types, register map and constants of the sensor fault debounce monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfdm_pkg;

    // debouncer phases
    typedef enum logic [1:0] {
        PH_NORMAL  = 2'd0,
        PH_PENDING = 2'd1,
        PH_FAULT   = 2'd2,
        PH_RECOVER = 2'd3
    } t_phase;

    // channel status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_RATE  = 2'd2;
    localparam logic [1:0] ST_COMM  = 2'd3;

    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMIDITY_HIGH_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_LOW_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_HIGH_LIMIT = 3'd4;

    // register reset values
    localparam logic [7:0]         RST_DEBOUNCE_LIMIT      = 8'd3;
    localparam logic signed [15:0] RST_TEMP_HIGH_LIMIT     = 16'sd5000;
    localparam logic [13:0]        RST_HUMIDITY_HIGH_LIMIT = 14'd8000;
    localparam logic [16:0]        RST_PRESSURE_LOW_LIMIT  = 17'd95000;
    localparam logic [16:0]        RST_PRESSURE_HIGH_LIMIT = 17'd106000;

    typedef struct packed {
        logic [1:0]         temp_status;
        logic [1:0]         press_status;
        logic [1:0]         hum_status;
        logic signed [15:0] temp_reading;
        logic [16:0]        press_reading;
        logic [13:0]        hum_reading;
    } t_item;

    typedef struct packed {
        logic comm_fault;
        logic data_fault;
        logic env_warning;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]   debounce_limit;
        logic signed [15:0] temp_high_limit;
        logic [13:0]        humidity_high_limit;
        logic [16:0]        pressure_low_limit;
        logic [16:0]        pressure_high_limit;
    } t_cfg;

    // raw conditions of one tick
    typedef struct packed {
        logic comm;
        logic data;
        logic env;
    } t_cond;

endpackage

>>> hdl/sfdm_stream_if.sv
// ----------------------------------------------------------------------------
// sfdm_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sfdm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/sensor_fault_debounce_monitor_core.sv
// ----------------------------------------------------------------------------
// sensor_fault_debounce_monitor_core
// Path: input beat to input register to result register to result beat.
// Throughput: one beat per cycle while the result side is not stalled; the debouncer next state is combinational.
// Reset: synchronous, active low; phases go to normal, counters to zero,
// limits to their defaults, both pipeline registers empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_fault_debounce_monitor_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sfdm_stream_if.sink                      i_item,
    sfdm_stream_if.source                    o_result,
    input  logic                             i_cfg_we,
    input  logic [sfdm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sfdm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    sfdm_pkg::t_cfg    w_cfg;
    sfdm_pkg::t_cond   w_cond;
    sfdm_pkg::t_item   r_s1_item;
    logic              r_s1_valid;
    sfdm_pkg::t_result r_result;
    sfdm_pkg::t_result w_result_next;
    logic              r_out_valid;
    logic              w_out_free;
    logic              w_adv;
    logic              w_in_acc;

    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_adv        = r_s1_valid && w_out_free;
    assign i_item.ready = !r_s1_valid || w_out_free;
    assign w_in_acc     = i_item.valid && i_item.ready;

    sfdm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_item <= i_item.payload;
        end
    end

    sfdm_cond u_cond (
        .i_item (r_s1_item),
        .i_cfg  (w_cfg),
        .o_cond (w_cond)
    );

    sfdm_debounce u_deb_comm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_cond       (w_cond.comm),
        .i_limit      (w_cfg.debounce_limit),
        .o_fault_next (w_result_next.comm_fault)
    );

    sfdm_debounce u_deb_data (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_cond       (w_cond.data),
        .i_limit      (w_cfg.debounce_limit),
        .o_fault_next (w_result_next.data_fault)
    );

    sfdm_debounce u_deb_env (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_cond       (w_cond.env),
        .i_limit      (w_cfg.debounce_limit),
        .o_fault_next (w_result_next.env_warning)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= w_result_next;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_result;

endmodule

>>> hdl/sfdm_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfdm_cfg_regs
// Limit and threshold registers behind the write-only configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfdm_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sfdm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sfdm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output sfdm_pkg::t_cfg                   o_cfg
);

    sfdm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_limit      <= sfdm_pkg::RST_DEBOUNCE_LIMIT;
            r_cfg.temp_high_limit     <= sfdm_pkg::RST_TEMP_HIGH_LIMIT;
            r_cfg.humidity_high_limit <= sfdm_pkg::RST_HUMIDITY_HIGH_LIMIT;
            r_cfg.pressure_low_limit  <= sfdm_pkg::RST_PRESSURE_LOW_LIMIT;
            r_cfg.pressure_high_limit <= sfdm_pkg::RST_PRESSURE_HIGH_LIMIT;
        end else if (i_cfg_we) begin
            // upper data bits beyond a register's width are dropped
            case (i_cfg_idx)
                sfdm_pkg::CFG_DEBOUNCE_LIMIT: begin
                    r_cfg.debounce_limit <= i_cfg_data[7:0];
                end
                sfdm_pkg::CFG_TEMP_HIGH_LIMIT: begin
                    r_cfg.temp_high_limit <= $signed(i_cfg_data[15:0]);
                end
                sfdm_pkg::CFG_HUMIDITY_HIGH_LIMIT: begin
                    r_cfg.humidity_high_limit <= i_cfg_data[13:0];
                end
                sfdm_pkg::CFG_PRESSURE_LOW_LIMIT: begin
                    r_cfg.pressure_low_limit <= i_cfg_data[16:0];
                end
                sfdm_pkg::CFG_PRESSURE_HIGH_LIMIT: begin
                    r_cfg.pressure_high_limit <= i_cfg_data[16:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/sfdm_cond.sv
// ----------------------------------------------------------------------------
// sfdm_cond
// Raw fault conditions of one tick: comm error, data error, environment limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfdm_cond (
    input  sfdm_pkg::t_item i_item,
    input  sfdm_pkg::t_cfg  i_cfg,
    output sfdm_pkg::t_cond o_cond
);

    logic w_temp_hi;
    logic w_hum_hi;
    logic w_press_lo;
    logic w_press_hi;

    function automatic logic is_data_err(input logic [1:0] st);
        return (st == sfdm_pkg::ST_RANGE) || (st == sfdm_pkg::ST_RATE);
    endfunction

    always_comb begin
        w_temp_hi  = $signed(i_item.temp_reading) > $signed(i_cfg.temp_high_limit);
        w_hum_hi   = i_item.hum_reading > i_cfg.humidity_high_limit;
        w_press_lo = i_item.press_reading < i_cfg.pressure_low_limit;
        w_press_hi = i_item.press_reading > i_cfg.pressure_high_limit;

        o_cond.comm = (i_item.temp_status == sfdm_pkg::ST_COMM) ||
                      (i_item.press_status == sfdm_pkg::ST_COMM) ||
                      (i_item.hum_status == sfdm_pkg::ST_COMM);
        o_cond.data = is_data_err(i_item.temp_status) ||
                      is_data_err(i_item.press_status) ||
                      is_data_err(i_item.hum_status);
        o_cond.env  = w_temp_hi || w_hum_hi || w_press_lo || w_press_hi;
    end

endmodule

>>> hdl/sfdm_debounce.sv
// ----------------------------------------------------------------------------
// sfdm_debounce
// Four-phase debouncer with a saturating confirmation counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfdm_debounce (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_cond,
    input  logic [sfdm_pkg::CNT_W-1:0]  i_limit,
    output logic                        o_fault_next
);

    sfdm_pkg::t_phase            r_phase;
    sfdm_pkg::t_phase            n_phase;
    logic [sfdm_pkg::CNT_W-1:0]  r_count;
    logic [sfdm_pkg::CNT_W-1:0]  n_count;
    logic [sfdm_pkg::CNT_W-1:0]  w_bump;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfdm_pkg::PH_NORMAL;
            r_count <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_comb begin
        // counter saturates at all ones
        w_bump  = (&r_count) ? r_count : r_count + {{(sfdm_pkg::CNT_W-1){1'b0}}, 1'b1};
        n_phase = r_phase;
        n_count = r_count;
        case (r_phase)
            sfdm_pkg::PH_NORMAL: begin
                if (i_cond) begin
                    n_phase = sfdm_pkg::PH_PENDING;
                    n_count = {{(sfdm_pkg::CNT_W-1){1'b0}}, 1'b1};
                end
            end
            sfdm_pkg::PH_PENDING: begin
                if (!i_cond) begin
                    n_phase = sfdm_pkg::PH_NORMAL;
                    n_count = '0;
                end else if (w_bump >= i_limit) begin
                    n_phase = sfdm_pkg::PH_FAULT;
                    n_count = '0;
                end else begin
                    n_count = w_bump;
                end
            end
            sfdm_pkg::PH_FAULT: begin
                if (!i_cond) begin
                    n_phase = sfdm_pkg::PH_RECOVER;
                    n_count = {{(sfdm_pkg::CNT_W-1){1'b0}}, 1'b1};
                end
            end
            sfdm_pkg::PH_RECOVER: begin
                // condition back during recovery: straight to fault
                if (i_cond) begin
                    n_phase = sfdm_pkg::PH_FAULT;
                    n_count = '0;
                end else if (w_bump >= i_limit) begin
                    n_phase = sfdm_pkg::PH_NORMAL;
                    n_count = '0;
                end else begin
                    n_count = w_bump;
                end
            end
            default: begin
                n_phase = sfdm_pkg::PH_NORMAL;
                n_count = '0;
            end
        endcase
        o_fault_next = (n_phase == sfdm_pkg::PH_FAULT);
    end

endmodule

>>> hdl/sfdm_checker.sv
// ----------------------------------------------------------------------------
// sfdm_checker
// Port-level checks of the monitor core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfdm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input sfdm_pkg::t_result i_out_payload
);

    // output beat held while stalled
    `SFDM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `SFDM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_payload))
    // empty result register never blocks the input side
    `SFDM_ASSERT_IMPLY(a_in_ready_free, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    // reset empties the pipeline
    `SFDM_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind sensor_fault_debounce_monitor_core sfdm_checker u_sfdm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_payload (o_result.payload)
);
